>>> sv/dnlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dnlf_pkg;

  localparam int MAX_WIRE_LENGTH_DEF  = 253;
  localparam int MAX_LABEL_LENGTH_DEF = 63;
  localparam int STORE_DEPTH_DEF      = 256;
  localparam int STACK_DEPTH          = 128;
  localparam int STACK_W              = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SKIP,
    S_HEAD,
    S_STACK,
    S_START,
    S_LEN,
    S_CHAR,
    S_ZERO
  } dnlf_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic push_fault;
    logic emit_head;
    logic latch_start;
    logic latch_len;
    logic emit_char;
    logic emit_zero;
  } dnlf_cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic fault_now;
    logic emit_now;
    logic last_lbl;
    logic left_one;
  } dnlf_stat_t;

endpackage
`default_nettype wire

>>> sv/dnlf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dnlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       end_of_name;

  modport source (output valid, output wire_byte, output end_of_name, input ready);
  modport sink   (input valid, input wire_byte, input end_of_name, output ready);
endinterface

interface dnlf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  byte_count;
  logic        fault;
  logic        last_word;

  modport source (output valid, output out_word, output byte_count, output fault,
                  output last_word, input ready);
  modport sink   (input valid, input out_word, input byte_count, input fault,
                  input last_word, output ready);
endinterface
`default_nettype wire

>>> sv/dns_name_lookup_format.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  request payload
// in_ch    in   wire_byte[7:0], end_of_name
// out_ch   out  out_word[31:0], byte_count[2:0], fault, last_word
//
// Loading takes one byte per cycle while the output register is free or being taken.
// A root byte starts emission: head byte, then per label a stack read, a start latch and
// a length read from the store, then each character and the zero byte.
// Reset (rst_n low, synchronous) clears the controller and the per-name counters.
// A stalled out_ch holds the head, character and zero-byte steps and blocks new requests.
module dns_name_lookup_format #(
  parameter int MAX_WIRE_LENGTH  = dnlf_pkg::MAX_WIRE_LENGTH_DEF,
  parameter int MAX_LABEL_LENGTH = dnlf_pkg::MAX_LABEL_LENGTH_DEF,
  parameter int STORE_DEPTH      = dnlf_pkg::STORE_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dnlf_in_if.sink   in_ch,
  dnlf_out_if.source out_ch
);

  dnlf_pkg::dnlf_cmd_t  cmd;
  dnlf_pkg::dnlf_stat_t st;

  dnlf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_end_of_name (in_ch.end_of_name),
    .in_ready       (in_ch.ready),
    .st             (st),
    .cmd            (cmd)
  );

  dnlf_dp #(
    .MAX_WIRE_LENGTH  (MAX_WIRE_LENGTH),
    .MAX_LABEL_LENGTH (MAX_LABEL_LENGTH),
    .STORE_DEPTH      (STORE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .wire_byte  (in_ch.wire_byte),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_word   (out_ch.out_word),
    .byte_count (out_ch.byte_count),
    .fault      (out_ch.fault),
    .last_word  (out_ch.last_word)
  );

endmodule
`default_nettype wire

>>> sv/dnlf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module dnlf_dp #(
  parameter int MAX_WIRE_LENGTH  = dnlf_pkg::MAX_WIRE_LENGTH_DEF,
  parameter int MAX_LABEL_LENGTH = dnlf_pkg::MAX_LABEL_LENGTH_DEF,
  parameter int STORE_DEPTH      = dnlf_pkg::STORE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         wire_byte,
  input  wire dnlf_pkg::dnlf_cmd_t cmd,
  output dnlf_pkg::dnlf_stat_t     st,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_word,
  output logic [2:0]              byte_count,
  output logic                    fault,
  output logic                    last_word
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic [7:0]                  name_store [STORE_DEPTH];
  logic [ADDR_W-1:0]           label_start_stack [dnlf_pkg::STACK_DEPTH];

  logic [7:0]                  label_count_r, label_count_nxt;
  logic [5:0]                  left_r, left_nxt;
  logic [8:0]                  wire_len_r, wire_len_nxt;

  logic [dnlf_pkg::STACK_W-1:0] lbl_idx_r, lbl_idx_nxt;
  logic [ADDR_W-1:0]           addr_r, addr_nxt;
  logic [ADDR_W-1:0]           stack_rd_r;
  logic [7:0]                  store_rd_r;
  logic [ADDR_W-1:0]           store_raddr;

  logic [23:0]                 pk_word_r, pk_word_nxt;
  logic [1:0]                  pk_cnt_r, pk_cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_word_r, out_word_nxt;
  logic [2:0]                  byte_count_r, byte_count_nxt;
  logic                        fault_r, fault_nxt;
  logic                        last_word_r, last_word_nxt;

  logic [9:0]                  next_len;
  logic                        char_ok;
  logic                        len_fault;
  logic [ADDR_W-1:0]           len_at;
  logic [ADDR_W-1:0]           char_at;
  logic [8:0]                  char_at_w;
  logic                        byte_go;
  logic [7:0]                  byte_val;
  logic                        byte_final;
  logic [31:0]                 merged;

  always_comb begin
    char_ok = (wire_byte inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) ||
              (wire_byte == 8'h2d) || (wire_byte == 8'h5f);
    next_len  = {1'b0, wire_len_r} + {2'b00, wire_byte} + 10'd1;
    len_fault = (wire_byte > 8'(MAX_LABEL_LENGTH)) ||
                (next_len > 10'(MAX_WIRE_LENGTH)) ||
                ((next_len - 10'd2) >= 10'(STORE_DEPTH)) ||
                (label_count_r >= 8'(dnlf_pkg::STACK_DEPTH));
    len_at    = ADDR_W'(wire_len_r - 9'd1);
    char_at_w = wire_len_r - 9'd1 - {3'b000, left_r};
    char_at   = char_at_w[ADDR_W-1:0];

    st.slot_ok  = !out_valid_r || out_ready;
    st.emit_now = (left_r == 6'd0) && (wire_byte == 8'd0) && (label_count_r != 8'd0);
    if (left_r == 6'd0) begin
      if (wire_byte == 8'd0) begin
        st.fault_now = (label_count_r == 8'd0);
      end else begin
        st.fault_now = len_fault;
      end
    end else begin
      st.fault_now = !char_ok;
    end
    st.last_lbl = (lbl_idx_r == '0);
    st.left_one = (left_r == 6'd1);
  end

  always_comb begin
    label_count_nxt = label_count_r;
    left_nxt        = left_r;
    wire_len_nxt    = wire_len_r;
    if (cmd.load) begin
      if (left_r == 6'd0) begin
        label_count_nxt = label_count_r + 8'd1;
        wire_len_nxt    = next_len[8:0];
        left_nxt        = wire_byte[5:0];
      end else begin
        left_nxt = left_r - 6'd1;
      end
    end
    if (cmd.latch_len) begin
      left_nxt = store_rd_r[5:0];
    end
    if (cmd.emit_char) begin
      left_nxt = left_r - 6'd1;
    end
    if (cmd.clear) begin
      label_count_nxt = 8'd0;
      left_nxt        = 6'd0;
      wire_len_nxt    = 9'd1;
    end
  end

  always_comb begin
    lbl_idx_nxt = lbl_idx_r;
    addr_nxt    = addr_r;
    store_raddr = addr_r;
    if (cmd.emit_head) begin
      lbl_idx_nxt = dnlf_pkg::STACK_W'(label_count_r - 8'd1);
    end
    if (cmd.emit_zero && !st.last_lbl) begin
      lbl_idx_nxt = lbl_idx_r - dnlf_pkg::STACK_W'(1);
    end
    if (cmd.latch_start) begin
      store_raddr = stack_rd_r;
      addr_nxt    = stack_rd_r + ADDR_W'(1);
    end
    if (cmd.emit_char) begin
      store_raddr = addr_r + ADDR_W'(1);
      addr_nxt    = addr_r + ADDR_W'(1);
    end
  end

  always_comb begin
    byte_go    = cmd.emit_head || cmd.emit_char || cmd.emit_zero;
    byte_final = cmd.emit_zero && st.last_lbl;
    if (cmd.emit_head) begin
      byte_val = wire_len_r[7:0] - 8'd1;
    end else if (cmd.emit_char) begin
      byte_val = store_rd_r;
    end else begin
      byte_val = 8'd0;
    end
    merged = {8'h00, pk_word_r} | ({24'h000000, byte_val} << {pk_cnt_r, 3'b000});

    pk_word_nxt    = pk_word_r;
    pk_cnt_nxt     = pk_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    byte_count_nxt = byte_count_r;
    fault_nxt      = fault_r;
    last_word_nxt  = last_word_r;
    if (cmd.push_fault) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = 32'd0;
      byte_count_nxt = 3'd0;
      fault_nxt      = 1'b1;
      last_word_nxt  = 1'b1;
    end else if (byte_go) begin
      if ((pk_cnt_r == 2'd3) || byte_final) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = merged;
        byte_count_nxt = {1'b0, pk_cnt_r} + 3'd1;
        fault_nxt      = 1'b0;
        last_word_nxt  = byte_final;
        pk_word_nxt    = 24'd0;
        pk_cnt_nxt     = 2'd0;
      end else begin
        pk_word_nxt = merged[23:0];
        pk_cnt_nxt  = pk_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (left_r == 6'd0) begin
        name_store[len_at] <= wire_byte;
      end else begin
        name_store[char_at] <= wire_byte;
      end
    end
    store_rd_r <= name_store[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (left_r == 6'd0)) begin
      label_start_stack[label_count_r[dnlf_pkg::STACK_W-1:0]] <= len_at;
    end
    stack_rd_r <= label_start_stack[lbl_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_count_r <= 8'd0;
      left_r        <= 6'd0;
      wire_len_r    <= 9'd1;
      pk_word_r     <= 24'd0;
      pk_cnt_r      <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      label_count_r <= label_count_nxt;
      left_r        <= left_nxt;
      wire_len_r    <= wire_len_nxt;
      pk_word_r     <= pk_word_nxt;
      pk_cnt_r      <= pk_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lbl_idx_r    <= lbl_idx_nxt;
    addr_r       <= addr_nxt;
    out_word_r   <= out_word_nxt;
    byte_count_r <= byte_count_nxt;
    fault_r      <= fault_nxt;
    last_word_r  <= last_word_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign byte_count = byte_count_r;
  assign fault      = fault_r;
  assign last_word  = last_word_r;

endmodule
`default_nettype wire

>>> sv/dnlf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dnlf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_end_of_name,
  output logic                      in_ready,
  input  wire dnlf_pkg::dnlf_stat_t st,
  output dnlf_pkg::dnlf_cmd_t       cmd
);

  dnlf_pkg::dnlf_state_t state_r, state_nxt;
  logic                  last_pend_r, last_pend_nxt;
  logic                  in_fire;
  logic                  fault_any;

  assign in_fire   = in_valid && in_ready;
  assign fault_any = st.fault_now || (in_end_of_name && !st.emit_now);

  always_comb begin
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    case (state_r)
      dnlf_pkg::S_IDLE: begin
        if (in_valid && st.slot_ok) begin
          if (fault_any) begin
            if (!in_end_of_name) begin
              state_nxt = dnlf_pkg::S_SKIP;
            end
          end else if (st.emit_now) begin
            state_nxt     = dnlf_pkg::S_HEAD;
            last_pend_nxt = in_end_of_name;
          end
        end
      end
      dnlf_pkg::S_SKIP: begin
        if (in_valid && in_end_of_name) begin
          state_nxt = dnlf_pkg::S_IDLE;
        end
      end
      dnlf_pkg::S_HEAD: begin
        if (st.slot_ok) begin
          state_nxt = dnlf_pkg::S_STACK;
        end
      end
      dnlf_pkg::S_STACK: state_nxt = dnlf_pkg::S_START;
      dnlf_pkg::S_START: state_nxt = dnlf_pkg::S_LEN;
      dnlf_pkg::S_LEN:   state_nxt = dnlf_pkg::S_CHAR;
      dnlf_pkg::S_CHAR: begin
        if (st.slot_ok && st.left_one) begin
          state_nxt = dnlf_pkg::S_ZERO;
        end
      end
      dnlf_pkg::S_ZERO: begin
        if (st.slot_ok) begin
          if (!st.last_lbl) begin
            state_nxt = dnlf_pkg::S_STACK;
          end else if (last_pend_r) begin
            state_nxt = dnlf_pkg::S_IDLE;
          end else begin
            state_nxt = dnlf_pkg::S_SKIP;
          end
        end
      end
      default: state_nxt = dnlf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      dnlf_pkg::S_IDLE: begin
        in_ready = st.slot_ok;
        if (in_fire) begin
          cmd.push_fault = fault_any;
          cmd.load       = !fault_any && !st.emit_now;
          cmd.clear      = in_end_of_name && fault_any;
        end
      end
      dnlf_pkg::S_SKIP: begin
        in_ready  = 1'b1;
        cmd.clear = in_valid && in_end_of_name;
      end
      dnlf_pkg::S_HEAD:  cmd.emit_head   = st.slot_ok;
      dnlf_pkg::S_STACK: cmd             = '0;
      dnlf_pkg::S_START: cmd.latch_start = 1'b1;
      dnlf_pkg::S_LEN:   cmd.latch_len   = 1'b1;
      dnlf_pkg::S_CHAR:  cmd.emit_char   = st.slot_ok;
      dnlf_pkg::S_ZERO: begin
        cmd.emit_zero = st.slot_ok;
        cmd.clear     = st.slot_ok && st.last_lbl && last_pend_r;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnlf_pkg::S_IDLE;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

endmodule
`default_nettype wire
